>>> rtl/ibs_pkg.sv
package ibs_pkg;

    localparam int CMD_W = 2;
    localparam int POS_W = 4;
    localparam int CNT_W = 3;
    localparam int OUT_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD_ELEM  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_INDEX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_ELEM,
        OP_LOAD_INDEX,
        OP_SEARCH
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [POS_W-1:0]       addr;
        logic [POS_W-1:0]       first;
        logic [POS_W-1:0]       last;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS_CHECK,
        ST_BS_CMP,
        ST_BLK_RD,
        ST_BLK_WAIT,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_RESULT
    } state_t;

endpackage

>>> rtl/ibs_front.sv
module ibs_front #(
    parameter int KEY_WIDTH   = 32,
    parameter int DATA_DEPTH  = 16,
    parameter int INDEX_DEPTH = 4,
    parameter int TDATA_W     = 48
) (
    input  logic [ibs_pkg::CMD_W-1:0] s_axis_tuser,
    input  logic [TDATA_W-1:0]        s_axis_tdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic                      q_full,
    output logic                      q_push,
    output ibs_pkg::op_t              q_op,
    output logic [KEY_WIDTH-1:0]      q_key
);

    logic keep;

    always_comb
    begin
        q_op.addr  = s_axis_tdata[ibs_pkg::POS_W-1:0];
        q_op.first = s_axis_tdata[KEY_WIDTH+7:KEY_WIDTH+4];
        q_op.last  = s_axis_tdata[KEY_WIDTH+11:KEY_WIDTH+8];
        q_key      = s_axis_tdata[KEY_WIDTH+3:4];
        case (s_axis_tuser)
            ibs_pkg::CMD_LOAD_ELEM:
            begin
                q_op.kind = ibs_pkg::OP_LOAD_ELEM;
                keep      = int'(q_op.addr) < DATA_DEPTH;
            end
            ibs_pkg::CMD_LOAD_INDEX:
            begin
                q_op.kind = ibs_pkg::OP_LOAD_INDEX;
                keep      = int'(q_op.addr) < INDEX_DEPTH;
            end
            ibs_pkg::CMD_SEARCH:
            begin
                q_op.kind = ibs_pkg::OP_SEARCH;
                keep      = 1'b1;
            end
            default:
            begin
                // unused command is taken and dropped
                q_op.kind = ibs_pkg::OP_SEARCH;
                keep      = 1'b0;
            end
        endcase
        s_axis_tready = !q_full;
        q_push        = s_axis_tvalid && !q_full && keep;
    end

endmodule

>>> rtl/ibs_queue.sv
module ibs_queue #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] fifo_mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push_ok, pop_ok;

    always_comb
    begin
        full    = count_reg == (PW+1)'(DEPTH);
        valid   = count_reg != '0;
        rdata   = fifo_mem_reg[rd_ptr_reg];
        push_ok = push && !full;
        pop_ok  = pop && valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fifo_mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/ibs_engine.sv
module ibs_engine #(
    parameter int KEY_WIDTH   = 32,
    parameter int DATA_DEPTH  = 16,
    parameter int INDEX_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ibs_pkg::CNT_W-1:0]  block_count,
    input  logic                       q_valid,
    input  ibs_pkg::op_t               q_op,
    input  logic [KEY_WIDTH-1:0]       q_key,
    output logic                       q_pop,
    output logic [ibs_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready
);

    localparam int AW = $clog2(DATA_DEPTH);
    localparam int IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int NW = $clog2(INDEX_DEPTH + 1);
    localparam int LW = ((NW > ibs_pkg::CNT_W) ? NW : ibs_pkg::CNT_W) + 1;
    localparam int PW = ibs_pkg::POS_W;

    // element and index stores
    logic [KEY_WIDTH-1:0] elem_mem      [DATA_DEPTH];
    logic [KEY_WIDTH-1:0] idx_max_mem   [INDEX_DEPTH];
    logic [PW-1:0]        idx_first_mem [INDEX_DEPTH];
    logic [PW-1:0]        idx_last_mem  [INDEX_DEPTH];

    logic [KEY_WIDTH-1:0] elem_rdata_reg;
    logic [KEY_WIDTH-1:0] idx_max_rdata_reg;
    logic [PW-1:0]        idx_first_rdata_reg;
    logic [PW-1:0]        idx_last_rdata_reg;

    logic                 elem_we, idx_we;
    logic [AW-1:0]        elem_raddr;
    logic [IW-1:0]        idx_raddr;

    ibs_pkg::state_t      state_reg, state_next;
    logic signed [LW-1:0] lo_reg, lo_next;
    logic signed [LW-1:0] hi_reg, hi_next;
    logic signed [LW-1:0] mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        last_reg, last_next;
    logic                 res_found_reg, res_found_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [PW-1:0]        out_pos_reg, out_pos_next;

    logic signed [LW-1:0] bn;
    logic [LW:0]          mid_sum;
    logic signed [LW-1:0] mid;
    logic                 pos_in_range;
    logic                 key_match;
    logic                 key_below, key_above;

    always_comb
    begin
        bn = (int'(block_count) > INDEX_DEPTH) ? LW'(INDEX_DEPTH) : LW'(block_count);
        mid_sum = {lo_reg[LW-1], lo_reg} + {hi_reg[LW-1], hi_reg};
        mid = mid_sum[LW:1];
        pos_in_range = int'(pos_reg) < DATA_DEPTH;
        key_match = elem_rdata_reg == key_reg;
        key_below = $signed(key_reg) < $signed(idx_max_rdata_reg);
        key_above = $signed(key_reg) > $signed(idx_max_rdata_reg);

        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        q_pop          = 1'b0;
        elem_we        = 1'b0;
        idx_we         = 1'b0;
        elem_raddr     = AW'(pos_reg);
        idx_raddr      = IW'(mid);

        case (state_reg)
            ibs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        ibs_pkg::OP_LOAD_ELEM:
                        begin
                            elem_we = 1'b1;
                        end
                        ibs_pkg::OP_LOAD_INDEX:
                        begin
                            idx_we = 1'b1;
                        end
                        ibs_pkg::OP_SEARCH:
                        begin
                            key_next   = q_key;
                            lo_next    = '0;
                            hi_next    = bn - LW'(1);
                            state_next = ibs_pkg::ST_BS_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ibs_pkg::ST_BS_CHECK:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid;
                    state_next = ibs_pkg::ST_BS_CMP;
                end
                else
                begin
                    state_next = ibs_pkg::ST_BLK_RD;
                end
            end
            ibs_pkg::ST_BS_CMP:
            begin
                if (key_below)
                begin
                    hi_next    = mid_reg - LW'(1);
                    state_next = ibs_pkg::ST_BS_CHECK;
                end
                else if (key_above)
                begin
                    lo_next    = mid_reg + LW'(1);
                    state_next = ibs_pkg::ST_BS_CHECK;
                end
                else
                begin
                    lo_next    = mid_reg;
                    state_next = ibs_pkg::ST_BLK_RD;
                end
            end
            ibs_pkg::ST_BLK_RD:
            begin
                idx_raddr = IW'(lo_reg);
                if (lo_reg < bn)
                begin
                    state_next = ibs_pkg::ST_BLK_WAIT;
                end
                else
                begin
                    // key above every block
                    res_found_next = 1'b0;
                    pos_next       = '0;
                    state_next     = ibs_pkg::ST_RESULT;
                end
            end
            ibs_pkg::ST_BLK_WAIT:
            begin
                pos_next   = idx_first_rdata_reg;
                last_next  = idx_last_rdata_reg;
                state_next = ibs_pkg::ST_SCAN;
            end
            ibs_pkg::ST_SCAN:
            begin
                if (pos_in_range)
                begin
                    state_next = ibs_pkg::ST_SCAN_CMP;
                end
                else if (pos_reg < last_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    res_found_next = 1'b0;
                    pos_next       = '0;
                    state_next     = ibs_pkg::ST_RESULT;
                end
            end
            ibs_pkg::ST_SCAN_CMP:
            begin
                if (key_match)
                begin
                    res_found_next = 1'b1;
                    state_next     = ibs_pkg::ST_RESULT;
                end
                else if (pos_reg < last_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ibs_pkg::ST_SCAN;
                end
                else
                begin
                    res_found_next = 1'b0;
                    pos_next       = '0;
                    state_next     = ibs_pkg::ST_RESULT;
                end
            end
            ibs_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_pos_next   = pos_reg;
                    state_next     = ibs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ibs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        res_found_reg <= res_found_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[AW'(q_op.addr)] <= q_key;
        end
        elem_rdata_reg <= elem_mem[elem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_max_mem[IW'(q_op.addr)]   <= q_key;
            idx_first_mem[IW'(q_op.addr)] <= q_op.first;
            idx_last_mem[IW'(q_op.addr)]  <= q_op.last;
        end
        idx_max_rdata_reg   <= idx_max_mem[idx_raddr];
        idx_first_rdata_reg <= idx_first_mem[idx_raddr];
        idx_last_rdata_reg  <= idx_last_mem[idx_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(ibs_pkg::OUT_W - PW - 1)'(0), out_pos_reg, out_found_reg};

endmodule

>>> rtl/indexed_block_search.sv
// indexed block search
// s_axis carries commands: tuser selects load element key, load index entry
// or search; tdata holds address, key, block first and block last positions.
// loads write the element or index store and give no result; a load to a
// slot beyond the store and the unused command are taken and dropped.
// m_axis carries one word per search: found flag and matching position.
// cfg_we/cfg_wdata write the number of index entries in use (reset 1).
// a front decoder feeds a four-word queue in front of the search engine,
// so up to four commands are taken while the engine is busy.
// a load is written from the idle state. a search probes the index with a
// binary search (at most log2(blocks) + 1 probes), reads the bounds of
// the chosen block, then scans its positions one at a time; each step
// waits on a registered read of the index or element store.
// the result sits in an output register; while the receiver stalls the
// engine finishes its search and then waits, and the queue keeps filling.
// reset empties the queue and output register and sets one block in use;
// the stores keep no reset and must be loaded before they are searched.
module indexed_block_search #(
    parameter int DATA_DEPTH  = 16,
    parameter int INDEX_DEPTH = 4,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ibs_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // address, key_value, block_first, block_last, zero pad
    input  logic [((KEY_WIDTH+19)/8)*8-1:0]    s_axis_tdata,
    // command
    input  logic [ibs_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // found, position, zero pad
    output logic [ibs_pkg::OUT_W-1:0]          m_axis_tdata
);

    localparam int TDATA_W     = ((KEY_WIDTH + 19) / 8) * 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int OP_W        = $bits(ibs_pkg::op_t);
    localparam int QW          = OP_W + KEY_WIDTH;

    logic [ibs_pkg::CNT_W-1:0] block_count_reg;
    logic                      q_full, q_push, q_pop, q_valid;
    ibs_pkg::op_t              front_op, back_op;
    logic [KEY_WIDTH-1:0]      front_key, back_key;
    logic [QW-1:0]             q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= ibs_pkg::CNT_W'(1);
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_wdata;
        end
    end

    ibs_front #(
        .KEY_WIDTH   (KEY_WIDTH),
        .DATA_DEPTH  (DATA_DEPTH),
        .INDEX_DEPTH (INDEX_DEPTH),
        .TDATA_W     (TDATA_W)
    ) u_front (
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (front_op),
        .q_key         (front_key)
    );

    ibs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({front_key, front_op}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign back_op  = ibs_pkg::op_t'(q_rdata[OP_W-1:0]);
    assign back_key = q_rdata[QW-1:OP_W];

    ibs_engine #(
        .KEY_WIDTH   (KEY_WIDTH),
        .DATA_DEPTH  (DATA_DEPTH),
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .block_count   (block_count_reg),
        .q_valid       (q_valid),
        .q_op          (back_op),
        .q_key         (back_key),
        .q_pop         (q_pop),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

endmodule

>>> rtl/ibs_checker.sv
module ibs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [ibs_pkg::OUT_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == '0)
        else $error("miss with nonzero position");

    // pad bits of the result word stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[ibs_pkg::OUT_W-1:5] == '0)
        else $error("result pad bits set");

    // no result right after reset
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind indexed_block_search ibs_checker u_ibs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/search_result_checker.sv
module search_result_checker #(
    parameter int DATA_DEPTH  = 16,
    parameter int INDEX_DEPTH = 4,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ibs_pkg::CNT_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // address, key_value, block_first, block_last, zero pad
    input  logic [((KEY_WIDTH+19)/8)*8-1:0]     s_axis_tdata,
    // command
    input  logic [ibs_pkg::CMD_W-1:0]           s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found, position, zero pad
    input  logic [ibs_pkg::OUT_W-1:0]           m_axis_tdata,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int POS_W = ibs_pkg::POS_W;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    logic signed [KEY_WIDTH-1:0] element_key [DATA_DEPTH];
    logic signed [KEY_WIDTH-1:0] block_max [INDEX_DEPTH];
    logic [POS_W-1:0]            block_lo [INDEX_DEPTH];
    logic [POS_W-1:0]            block_hi [INDEX_DEPTH];
    logic [ibs_pkg::CNT_W-1:0]   blocks_in_use;
    search_result_t              results_due [$];

    wire [POS_W-1:0]            in_addr  = s_axis_tdata[POS_W-1:0];
    wire signed [KEY_WIDTH-1:0] in_key   = s_axis_tdata[POS_W +: KEY_WIDTH];
    wire [POS_W-1:0]            in_first = s_axis_tdata[POS_W+KEY_WIDTH +: POS_W];
    wire [POS_W-1:0]            in_last  = s_axis_tdata[2*POS_W+KEY_WIDTH +: POS_W];
    wire                        out_found = m_axis_tdata[0];
    wire [POS_W-1:0]            out_pos   = m_axis_tdata[1 +: POS_W];

    function automatic search_result_t find_key(input logic signed [KEY_WIDTH-1:0] k);
        int             nblk;
        int             lo;
        int             hi;
        int             mid;
        int             p;
        int             stop;
        search_result_t r;
        nblk = (blocks_in_use > INDEX_DEPTH) ? INDEX_DEPTH : int'(blocks_in_use);
        lo = 0;
        hi = nblk - 1;
        r = '0;
        // first block whose largest key is not below k
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (k < block_max[mid])
                hi = mid - 1;
            else if (k > block_max[mid])
                lo = mid + 1;
            else
            begin
                lo = mid;
                hi = mid - 1;
            end
        end
        if (lo < nblk)
        begin
            p = int'(block_lo[lo]);
            stop = int'(block_hi[lo]);
            while (p < stop && element_key[p] != k)
                p++;
            if (p < DATA_DEPTH && element_key[p] == k)
            begin
                r.found = 1'b1;
                r.position = p[POS_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        search_result_t want;
        if (!rst_n)
        begin
            results_due.delete();
            blocks_in_use <= ibs_pkg::CNT_W'(1);
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                blocks_in_use <= cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual found=%0b position=%0d",
                             $time, out_found, out_pos);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.found !== out_found || want.position !== out_pos)
                    begin
                        $display("%0t: mismatch, expected found=%0b pos=%0d, actual found=%0b pos=%0d",
                                 $time, want.found, want.position, out_found, out_pos);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    ibs_pkg::CMD_LOAD_ELEM:
                    begin
                        if (in_addr < DATA_DEPTH)
                            element_key[in_addr] <= in_key;
                    end
                    ibs_pkg::CMD_LOAD_INDEX:
                    begin
                        if (in_addr < INDEX_DEPTH)
                        begin
                            block_max[in_addr] <= in_key;
                            block_lo[in_addr] <= in_first;
                            block_hi[in_addr] <= in_last;
                        end
                    end
                    ibs_pkg::CMD_SEARCH:
                        results_due.push_back(find_key(in_key));
                    default:
                        ;
                endcase
            end
            pending <= results_due.size();
        end
    end

endmodule

>>> dv/tb_top.sv
module tb_top;

    localparam int DATA_DEPTH  = 16;
    localparam int INDEX_DEPTH = 4;
    localparam int KEY_WIDTH   = 32;
    localparam int IN_W        = ((KEY_WIDTH + 19) / 8) * 8;
    localparam int POS_W       = ibs_pkg::POS_W;
    localparam int NUM_PHASES  = 18;
    localparam int OPS_PER_PHASE = 30;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 4000;

    localparam logic [ibs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [ibs_pkg::CNT_W-1:0]     cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // address, key_value, block_first, block_last, zero pad
    logic [IN_W-1:0]               s_axis_tdata = '0;
    // command
    logic [ibs_pkg::CMD_W-1:0]     s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // found, position, zero pad
    logic [ibs_pkg::OUT_W-1:0]     m_axis_tdata;

    int fail_count;
    int pending;
    int stuck_cycles = 0;
    int stall_left = 0;
    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;

    logic signed [31:0] table_keys [DATA_DEPTH];
    logic signed [31:0] table_max [INDEX_DEPTH];
    logic [POS_W-1:0]   blk_start [INDEX_DEPTH];
    logic [POS_W-1:0]   blk_end [INDEX_DEPTH];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    indexed_block_search #(
        .DATA_DEPTH(DATA_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH),
        .KEY_WIDTH(KEY_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    search_result_checker #(
        .DATA_DEPTH(DATA_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH),
        .KEY_WIDTH(KEY_WIDTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count),
        .pending(pending)
    );

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [ibs_pkg::CMD_W-1:0] cmd, input int addr,
                             input logic [31:0] key, input int first, input int last);
        @(negedge clk);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {{(IN_W - 3*POS_W - KEY_WIDTH){1'b0}}, POS_W'(last), POS_W'(first),
                         key, POS_W'(addr)};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic search(input logic [31:0] key);
        send_word(ibs_pkg::CMD_SEARCH, $urandom, key, $urandom, $urandom);
    endtask

    task automatic write_block_count(input logic [ibs_pkg::CNT_W-1:0] count);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // loads give no result, so let the engine finish them
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_table();
        logic signed [31:0] t;
        int                 c1;
        int                 c2;
        int                 c3;
        bit                 wide;
        wide = $urandom_range(0, 1);
        for (int i = 0; i < DATA_DEPTH; i++)
            table_keys[i] = wide ? $urandom : $signed($urandom_range(0, 60)) - 30;
        // mostly sorted tables, sometimes left unordered
        if ($urandom_range(0, 4) != 0)
        begin
            for (int i = 1; i < DATA_DEPTH; i++)
                for (int j = i; j > 0 && table_keys[j-1] > table_keys[j]; j--)
                begin
                    t = table_keys[j];
                    table_keys[j] = table_keys[j-1];
                    table_keys[j-1] = t;
                end
        end
        c1 = $urandom_range(1, 13);
        c2 = $urandom_range(c1 + 1, 14);
        c3 = $urandom_range(c2 + 1, 15);
        blk_start[0] = '0;
        blk_end[0] = POS_W'(c1 - 1);
        blk_start[1] = POS_W'(c1);
        blk_end[1] = POS_W'(c2 - 1);
        blk_start[2] = POS_W'(c2);
        blk_end[2] = POS_W'(c3 - 1);
        blk_start[3] = POS_W'(c3);
        blk_end[3] = POS_W'(DATA_DEPTH - 1);
        for (int j = 0; j < INDEX_DEPTH; j++)
        begin
            table_max[j] = table_keys[blk_end[j]];
            if ($urandom_range(0, 3) == 0 && table_max[j] != KEY_MAX)
                table_max[j] = table_max[j] + 1;
        end
        for (int i = 0; i < DATA_DEPTH; i++)
            send_word(ibs_pkg::CMD_LOAD_ELEM, i, table_keys[i], $urandom, $urandom);
        for (int j = 0; j < INDEX_DEPTH; j++)
            send_word(ibs_pkg::CMD_LOAD_INDEX, j, table_max[j], int'(blk_start[j]),
                      int'(blk_end[j]));
    endtask

    task automatic random_op();
        int                 pick;
        int                 a;
        logic signed [31:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            search(table_keys[$urandom_range(0, DATA_DEPTH - 1)]);
        else if (pick < 52)
            search(table_max[$urandom_range(0, INDEX_DEPTH - 1)]);
        else if (pick < 64)
            search(table_keys[$urandom_range(0, DATA_DEPTH - 1)] + ($urandom_range(0, 1) ? 1 : -1));
        else if (pick < 71)
        begin
            case ($urandom_range(0, 3))
                0: search(KEY_MIN);
                1: search(KEY_MAX);
                2: search(0);
                default: search(-1);
            endcase
        end
        else if (pick < 80)
            search($urandom);
        else if (pick < 89)
        begin
            a = $urandom_range(0, DATA_DEPTH - 1);
            k = $urandom;
            table_keys[a] = k;
            send_word(ibs_pkg::CMD_LOAD_ELEM, a, k, $urandom, $urandom);
        end
        else if (pick < 93)
            send_word(ibs_pkg::CMD_LOAD_INDEX, $urandom_range(INDEX_DEPTH, 15), $urandom,
                      $urandom, $urandom);
        else if (pick < 96)
            send_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            // reversed or single-position block on a live slot
            a = $urandom_range(0, INDEX_DEPTH - 1);
            blk_start[a] = POS_W'($urandom_range(0, 15));
            blk_end[a] = POS_W'($urandom_range(0, blk_start[a]));
            send_word(ibs_pkg::CMD_LOAD_INDEX, a, table_max[a], int'(blk_start[a]),
                      int'(blk_end[a]));
        end
    endtask

    initial
    begin
        logic [ibs_pkg::CNT_W-1:0] count;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // one block over positions 0..3
        send_word(ibs_pkg::CMD_LOAD_ELEM, 0, KEY_MIN, 15, 15);
        send_word(ibs_pkg::CMD_LOAD_ELEM, 1, -1, 0, 0);
        send_word(ibs_pkg::CMD_LOAD_ELEM, 2, 0, 15, 0);
        send_word(ibs_pkg::CMD_LOAD_ELEM, 3, 1000, 0, 15);
        send_word(ibs_pkg::CMD_LOAD_INDEX, 0, 1000, 0, 3);
        search(KEY_MIN);
        search(1000);
        search(0);
        search(-1);
        search(7);
        search(KEY_MAX);
        // reversed bounds: only the first position counts
        send_word(ibs_pkg::CMD_LOAD_INDEX, 0, 1000, 3, 1);
        search(1000);
        search(-1);
        send_word(ibs_pkg::CMD_LOAD_INDEX, 0, 1000, 2, 2);
        search(0);
        // slot beyond the index store and unused command are dropped
        send_word(ibs_pkg::CMD_LOAD_INDEX, 15, KEY_MIN, 0, 0);
        send_word(CMD_UNUSED, 15, KEY_MAX, 15, 15);
        search(KEY_MIN);
        write_block_count(0);
        search(0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: count = 4;
                1: count = 7;
                2: count = 1;
                3: count = 0;
                4: count = 2;
                5: count = 3;
                6: count = 5;
                7: count = 6;
                default: count = ibs_pkg::CNT_W'($urandom_range(0, 7));
            endcase
            write_block_count(count);
            src_idle = (phase < NUM_PHASES - 2) && (phase % 3 != 2);
            sink_idle = (phase < NUM_PHASES - 2) && (phase % 4 != 3);
            build_table();
            for (int n = 0; n < OPS_PER_PHASE; n++)
                random_op();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/ibs_pkg.sv
rtl/ibs_front.sv
rtl/ibs_queue.sv
rtl/ibs_engine.sv
rtl/indexed_block_search.sv
rtl/ibs_checker.sv
dv/search_result_checker.sv
dv/tb_top.sv
